// File: rtl/rfp_pkg.sv
`default_nettype none

package rfp_pkg;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_COUNT  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FLOAT_MASK    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FILTER_COLUMN = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_COMPARE_OP    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_COMPARE_VALUE = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_PROJECT_MASK  = 3'd5;

    // compare operators
    localparam logic [2:0] OP_EQ = 3'd0;
    localparam logic [2:0] OP_NE = 3'd1;
    localparam logic [2:0] OP_GT = 3'd2;
    localparam logic [2:0] OP_GE = 3'd3;
    localparam logic [2:0] OP_LT = 3'd4;
    localparam logic [2:0] OP_LE = 3'd5;

    // column masks are fixed at 16 bits
    localparam int MASK_W = 16;

    typedef struct packed {
        logic [4:0]        column_count;
        logic [MASK_W-1:0] float_column_mask;
        logic [3:0]        filter_column;
        logic [2:0]        compare_op;
        logic [31:0]       compare_value;
        logic [MASK_W-1:0] project_mask;
    } rfp_cfg_t;

    function automatic logic [31:0] byte_reverse(input logic [31:0] w);
        return ((w & 32'hFF00_0000) >> 24) | ((w & 32'h00FF_0000) >> 8) |
               ((w & 32'h0000_FF00) << 8)  | ((w & 32'h0000_00FF) << 24);
    endfunction

    // single float to signed integer, truncate toward zero, saturating, nan to zero
    function automatic logic [31:0] float_to_int(input logic [31:0] b);
        logic        neg;
        logic [7:0]  ex;
        logic [22:0] frac;
        logic [31:0] man;
        logic [31:0] mag;
        logic [31:0] res;
        neg  = b[31];
        ex   = b[30:23];
        frac = b[22:0];
        man  = {8'b0, 1'b1, frac};
        mag  = '0;
        if (ex == 8'hFF && frac != '0) begin
            res = '0;
        end
        else if (ex < 8'd127) begin
            res = '0;
        end
        else if (ex >= 8'd158) begin
            res = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        else begin
            if (ex >= 8'd150) begin
                mag = man << (ex - 8'd150);
            end
            else begin
                mag = man >> (8'd150 - ex);
            end
            res = neg ? (32'd0 - mag) : mag;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: rtl/rfp_ram.sv
`default_nettype none

module rfp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/rfp_cfg_regs.sv
`default_nettype none

module rfp_cfg_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    output      logic                             cfg_ready,
    input  wire logic [rfp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [rfp_pkg::CFG_DATA_W-1:0]   cfg_data,
    output      rfp_pkg::rfp_cfg_t                cfg
);

    rfp_pkg::rfp_cfg_t cfg_reg;
    rfp_pkg::rfp_cfg_t cfg_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                rfp_pkg::REG_COLUMN_COUNT:  cfg_next.column_count      = cfg_data[4:0];
                rfp_pkg::REG_FLOAT_MASK:    cfg_next.float_column_mask = cfg_data[15:0];
                rfp_pkg::REG_FILTER_COLUMN: cfg_next.filter_column     = cfg_data[3:0];
                rfp_pkg::REG_COMPARE_OP:    cfg_next.compare_op        = cfg_data[2:0];
                rfp_pkg::REG_COMPARE_VALUE: cfg_next.compare_value     = cfg_data[31:0];
                rfp_pkg::REG_PROJECT_MASK:  cfg_next.project_mask      = cfg_data[15:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.column_count      <= 5'd1;
            cfg_reg.float_column_mask <= '0;
            cfg_reg.filter_column     <= '0;
            cfg_reg.compare_op        <= '0;
            cfg_reg.compare_value     <= '0;
            cfg_reg.project_mask      <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: rtl/rfp_convert.sv
`default_nettype none

module rfp_convert (
    input  wire logic [31:0] raw_word,
    input  wire logic        is_float,
    output      logic [31:0] word
);

    logic [31:0] swapped;

    // file bytes are little-endian, value wants them reversed
    assign swapped = rfp_pkg::byte_reverse(raw_word);
    assign word    = is_float ? rfp_pkg::float_to_int(swapped) : swapped;

endmodule

`default_nettype wire

// File: rtl/row_filter_and_project_core.sv
// input: a column word is taken every cycle while a row streams in
// at the row's last word: the filter column is read (ST_FILT) and tested (ST_CMP), then the
// projected columns are read from the row memory and registered onto the output
// readout: one projected column per cycle from the row memory's read port while out_ready
// holds high; no input is taken until the last projected column is in the output register
// reset: control state and configuration back to defaults at once, row memory is not cleared
`default_nettype none

module row_filter_and_project_core #(
    parameter int MAX_COLUMNS = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // configuration writes
    input  wire logic                             cfg_valid,
    output      logic                             cfg_ready,
    input  wire logic [rfp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [rfp_pkg::CFG_DATA_W-1:0]   cfg_data,
    // column words in
    input  wire logic                             in_valid,
    output      logic                             in_ready,
    input  wire logic [31:0]                      raw_word,
    // projected columns out
    output      logic                             out_valid,
    input  wire logic                             out_ready,
    output      logic [3:0]                       column_index,
    output      logic signed [31:0]               column_value,
    output      logic                             last_of_row
);

    localparam int AW = $clog2(MAX_COLUMNS);
    localparam int CW = $clog2(MAX_COLUMNS + 1);

    // sequencer states
    localparam logic [1:0] ST_IN     = 2'd0;  // streaming row words into memory
    localparam logic [1:0] ST_FILT   = 2'd1;  // filter column read in flight
    localparam logic [1:0] ST_CMP    = 2'd2;  // predicate on read data
    localparam logic [1:0] ST_SCAN   = 2'd3;  // reading out projected columns

    rfp_pkg::rfp_cfg_t cfg;

    logic [1:0]              state_reg, state_next;
    logic [AW-1:0]           pos_reg, pos_next;
    logic [rfp_pkg::MASK_W-1:0] pending_reg, pending_next;
    logic                    rd_busy_reg, rd_busy_next;
    logic                    rd_last_reg, rd_last_next;
    logic [3:0]              rd_idx_reg, rd_idx_next;
    logic                    out_valid_reg, out_valid_next;
    logic [3:0]              out_index_reg, out_index_next;
    logic [31:0]             out_value_reg, out_value_next;
    logic                    out_last_reg, out_last_next;

    logic [CW-1:0]           count_eff;
    logic                    row_end;
    logic                    is_float;
    logic [31:0]             conv_word;
    logic                    in_fire;
    logic [rfp_pkg::MASK_W-1:0] eff_mask;
    logic                    filter_ok;
    logic                    pred;
    logic [3:0]              scan_idx;
    logic [rfp_pkg::MASK_W-1:0] pending_after;
    logic                    out_free;
    logic                    capture;
    logic                    issue;
    logic                    ram_re;
    logic [AW-1:0]           ram_raddr;
    logic [31:0]             ram_rdata;

    rfp_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // columns per row, zero acts as one, clipped to the memory depth
    always_comb
    begin
        if (cfg.column_count == '0)
        begin
            count_eff = CW'(1);
        end
        else if (32'(cfg.column_count) > 32'(MAX_COLUMNS))
        begin
            count_eff = CW'(MAX_COLUMNS);
        end
        else
        begin
            count_eff = CW'(cfg.column_count);
        end
    end

    assign in_ready = (state_reg == ST_IN);
    assign in_fire  = in_valid && in_ready;
    assign row_end  = (32'(pos_reg) + 32'd1) >= 32'(count_eff);
    assign is_float = (32'(pos_reg) < 32'd16) && cfg.float_column_mask[4'(pos_reg)];

    rfp_convert u_conv (
        .raw_word (raw_word),
        .is_float (is_float),
        .word     (conv_word)
    );

    // one row of converted words; written on every accepted word
    rfp_ram #(
        .WIDTH (32),
        .DEPTH (MAX_COLUMNS)
    ) u_row_ram (
        .clk   (clk),
        .we    (in_fire),
        .waddr (pos_reg),
        .wdata (conv_word),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // projected columns that fall inside the row
    always_comb
    begin
        for (int c = 0; c < rfp_pkg::MASK_W; c++)
        begin
            eff_mask[c] = cfg.project_mask[c] && (c < 32'(count_eff));
        end
    end

    assign filter_ok = 32'(cfg.filter_column) < 32'(count_eff);

    // signed compare of the filter column against the compare value
    always_comb
    begin
        unique case (cfg.compare_op)
            rfp_pkg::OP_EQ: pred = $signed(ram_rdata) == $signed(cfg.compare_value);
            rfp_pkg::OP_NE: pred = $signed(ram_rdata) != $signed(cfg.compare_value);
            rfp_pkg::OP_GT: pred = $signed(ram_rdata) >  $signed(cfg.compare_value);
            rfp_pkg::OP_GE: pred = $signed(ram_rdata) >= $signed(cfg.compare_value);
            rfp_pkg::OP_LT: pred = $signed(ram_rdata) <  $signed(cfg.compare_value);
            rfp_pkg::OP_LE: pred = $signed(ram_rdata) <= $signed(cfg.compare_value);
            default:        pred = 1'b0;
        endcase
    end

    // lowest pending column goes next, so columns leave in ascending order
    always_comb
    begin
        scan_idx = '0;
        for (int c = rfp_pkg::MASK_W - 1; c >= 0; c--)
        begin
            if (pending_reg[c])
            begin
                scan_idx = 4'(c);
            end
        end
    end

    assign pending_after = pending_reg & ~(16'd1 << scan_idx);

    // one read in flight; its data waits in the memory output until the
    // output register can take it
    assign out_free = !out_valid_reg || out_ready;
    assign capture  = (state_reg == ST_SCAN) && rd_busy_reg && out_free;
    assign issue    = (state_reg == ST_SCAN) && (pending_reg != '0) &&
                      (!rd_busy_reg || capture);

    always_comb
    begin
        ram_re    = 1'b0;
        ram_raddr = AW'(cfg.filter_column);
        if (state_reg == ST_FILT)
        begin
            ram_re = 1'b1;
        end
        else if (issue)
        begin
            ram_re    = 1'b1;
            ram_raddr = AW'(scan_idx);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        pending_next   = pending_reg;
        rd_busy_next   = rd_busy_reg;
        rd_last_next   = rd_last_reg;
        rd_idx_next    = rd_idx_reg;
        out_valid_next = out_valid_reg;
        out_index_next = out_index_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;

        // output register drains whatever the sequencer does
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IN:
            begin
                if (in_fire)
                begin
                    if (row_end)
                    begin
                        pos_next   = '0;
                        state_next = ST_FILT;
                    end
                    else
                    begin
                        pos_next = pos_reg + AW'(1);
                    end
                end
            end
            ST_FILT:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (filter_ok && pred && (eff_mask != '0))
                begin
                    pending_next = eff_mask;
                    rd_busy_next = 1'b0;
                    state_next   = ST_SCAN;
                end
                else
                begin
                    state_next = ST_IN;
                end
            end
            ST_SCAN:
            begin
                if (capture)
                begin
                    out_valid_next = 1'b1;
                    out_index_next = rd_idx_reg;
                    out_value_next = ram_rdata;
                    out_last_next  = rd_last_reg;
                    rd_busy_next   = 1'b0;
                    if (rd_last_reg)
                    begin
                        state_next = ST_IN;
                    end
                end
                if (issue)
                begin
                    rd_busy_next = 1'b1;
                    rd_idx_next  = scan_idx;
                    rd_last_next = (pending_after == '0);
                    pending_next = pending_after;
                end
            end
            default:
            begin
                state_next = ST_IN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IN;
            pos_reg       <= '0;
            pending_reg   <= '0;
            rd_busy_reg   <= 1'b0;
            rd_last_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            pending_reg   <= pending_next;
            rd_busy_reg   <= rd_busy_next;
            rd_last_reg   <= rd_last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        rd_idx_reg    <= rd_idx_next;
        out_index_reg <= out_index_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid    = out_valid_reg;
    assign column_index = out_index_reg;
    assign column_value = $signed(out_value_reg);
    assign last_of_row  = out_last_reg;

endmodule

`default_nettype wire

// File: rtl/rfp_checker.sv
`default_nettype none

module rfp_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             in_ready,
    input wire logic                             out_valid,
    input wire logic                             out_ready,
    input wire logic [3:0]                       column_index,
    input wire logic signed [31:0]               column_value,
    input wire logic                             last_of_row
);

    // async reset empties the output at once
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("output request visible during reset");

    // a held request that is not last means the row readout is still busy
    a_busy_mid_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_row |-> !in_ready)
        else $error("input taken while a row is still being read out");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output request dropped before taken");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(column_index) && $stable(column_value) &&
                                    $stable(last_of_row))
        else $error("output payload changed while stalled");

endmodule

bind row_filter_and_project_core rfp_checker u_rfp_checker (.*);

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int ROW_MAX       = 16;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 200;
    localparam int RANDOM_WORDS  = 186;
    localparam int REPORT_LIMIT  = 10;

    // register slots past the last defined one, writes there must change nothing
    localparam logic [rfp_pkg::CFG_INDEX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [rfp_pkg::CFG_INDEX_W-1:0] REG_SPARE_7 = 3'd7;
    // operator codes with no meaning, no row gets through with them
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    // float corner values, column 0 in the low word:
    // +inf, -inf, nan, negative nan, 2^31, -2^31, just under 2^31, 1.5, -1.5,
    // just under one, denormal, negative zero, 2^23+1, 2^23-0.5, -123456.9, 123.0
    localparam logic [16*32-1:0] FLOAT_CASES = {
        32'h42F6_0000, 32'hC7F1_207A, 32'h4AFF_FFFF, 32'h4B00_0001,
        32'h8000_0000, 32'h0000_0001, 32'h3F7F_FFFF, 32'hBFC0_0000,
        32'h3FC0_0000, 32'h4EFF_FFFF, 32'hCF00_0000, 32'h4F00_0000,
        32'hFF80_0001, 32'h7FC0_0000, 32'hFF80_0000, 32'h7F80_0000
    };

    typedef struct packed {
        logic [3:0]  idx;
        logic [31:0] value;
        logic        is_last;
    } proj_col_t;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [rfp_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [rfp_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                            in_valid  = 1'b0;
    logic                            in_ready;
    logic [31:0]                     raw_word  = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic [3:0]                      column_index;
    logic signed [31:0]              column_value;
    logic                            last_of_row;

    // column words still to be offered, projected columns still owed by the block
    logic [31:0] pending_words[$];
    proj_col_t   expected_cols[$];

    // shadow of the block: register values, buffered row, next column slot
    rfp_pkg::rfp_cfg_t regs;
    logic [31:0] row_words [ROW_MAX];
    int          col_pos;

    int          mismatches = 0;
    proj_col_t   want_col;

    // idling control: a calm phase with no gaps, and one long hold on the output
    bit          no_idle   = 1'b0;
    bit          hold_arm  = 1'b0;
    bit          hold_done = 1'b0;
    int          hold_left = 0;

    row_filter_and_project_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .raw_word     (raw_word),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .column_index (column_index),
        .column_value (column_value),
        .last_of_row  (last_of_row)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // file byte order to value order
    function automatic logic [31:0] swap_bytes(input logic [31:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

    // zero acts as one, anything past the row store acts as its size
    function automatic int eff_count(input logic [4:0] cc);
        if (cc == 5'd0)
            return 1;
        if (int'(cc) > ROW_MAX)
            return ROW_MAX;
        return int'(cc);
    endfunction

    // single float to int, chop toward zero, clamp at the int range, nan to zero
    function automatic logic [31:0] float_trunc(input logic [31:0] f);
        logic [7:0]  ex;
        logic [63:0] wide;
        logic [31:0] mag;
        ex = f[30:23];
        if (ex == 8'hFF && f[22:0] != 23'd0)
            return 32'd0;
        if (ex < 8'd127)
            return 32'd0;
        // unbiased exponent 31 and up does not fit, infinity lands here too
        if (ex > 8'd157)
            return f[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        wide = {40'd0, 1'b1, f[22:0]} << (ex - 8'd127);
        mag  = wide[54:23];
        return f[31] ? -mag : mag;
    endfunction

    // take one accepted column word into the shadow row, queue what the row emits
    task automatic predict_projection(input logic [31:0] raw);
        int          count;
        int          pos;
        int          last_col;
        int          c;
        logic [31:0] w;
        logic [31:0] lhs;
        bit          pass;
        proj_col_t   entry;
        count = eff_count(regs.column_count);
        pos   = col_pos;
        w     = swap_bytes(raw);
        if (regs.float_column_mask[pos])
            w = float_trunc(w);
        row_words[pos] = w;
        // row goes on until the slot reaches the count, a shrunk count ends it now
        if (pos + 1 < count)
        begin
            col_pos = pos + 1;
            return;
        end
        col_pos = 0;
        pass    = 1'b0;
        // a filter column past the row end blocks every row
        if (regs.filter_column < count)
        begin
            lhs = row_words[regs.filter_column];
            case (regs.compare_op)
                rfp_pkg::OP_EQ: pass = (lhs == regs.compare_value);
                rfp_pkg::OP_NE: pass = (lhs != regs.compare_value);
                rfp_pkg::OP_GT: pass = ($signed(lhs) >  $signed(regs.compare_value));
                rfp_pkg::OP_GE: pass = ($signed(lhs) >= $signed(regs.compare_value));
                rfp_pkg::OP_LT: pass = ($signed(lhs) <  $signed(regs.compare_value));
                rfp_pkg::OP_LE: pass = ($signed(lhs) <= $signed(regs.compare_value));
                default:        pass = 1'b0;
            endcase
        end
        if (!pass)
            return;
        // mask bits past the row end are dropped, an empty mask gives nothing
        last_col = count;
        for (c = 0; c < count; c++)
            if (regs.project_mask[c])
                last_col = c;
        for (c = 0; c < count; c++)
        begin
            if (regs.project_mask[c])
            begin
                entry.idx     = c[3:0];
                entry.value   = row_words[c];
                entry.is_last = (c == last_col);
                expected_cols.insert(expected_cols.size(), entry);
            end
        end
    endtask

    // one register write, returns at the accepting edge with cfg_valid still high
    task automatic write_reg(input logic [rfp_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            rfp_pkg::REG_COLUMN_COUNT:  regs.column_count      = data[4:0];
            rfp_pkg::REG_FLOAT_MASK:    regs.float_column_mask = data[15:0];
            rfp_pkg::REG_FILTER_COLUMN: regs.filter_column     = data[3:0];
            rfp_pkg::REG_COMPARE_OP:    regs.compare_op        = data[2:0];
            rfp_pkg::REG_COMPARE_VALUE: regs.compare_value     = data;
            rfp_pkg::REG_PROJECT_MASK:  regs.project_mask      = data[15:0];
            default:                    ;
        endcase
    endtask

    // all six registers, with junk above each field narrower than the word, which the block must drop
    task automatic apply_config(input logic [4:0] cc, input logic [15:0] fmask,
                                input logic [3:0] filt, input logic [2:0] op,
                                input logic [31:0] cval, input logic [15:0] pmask);
        logic [31:0] junk;
        junk = $urandom;
        write_reg(rfp_pkg::REG_COLUMN_COUNT,  {junk[31:5], cc});
        write_reg(rfp_pkg::REG_FLOAT_MASK,    {junk[31:16], fmask});
        write_reg(rfp_pkg::REG_FILTER_COLUMN, {junk[31:4], filt});
        write_reg(rfp_pkg::REG_COMPARE_OP,    {junk[31:3], op});
        write_reg(rfp_pkg::REG_COMPARE_VALUE, cval);
        write_reg(rfp_pkg::REG_PROJECT_MASK,  {junk[31:16], pmask});
        cfg_valid <= 1'b0;
    endtask

    // wait for every request taken and every column seen, then let the block settle
    task automatic wait_idle();
        while (pending_words.size() != 0 || in_valid || expected_cols.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // random column word in file byte order, floats and near-hits of the compare value
    function automatic logic [31:0] make_column(input bit as_float, input logic [31:0] cmp);
        logic [31:0] r;
        logic [31:0] v;
        logic [7:0]  ex;
        int          sel;
        r   = $urandom;
        sel = int'($urandom_range(9));
        if (as_float)
        begin
            if (sel == 0)
                v = {r[31], 8'hFF, (r[0] ? r[22:0] : 23'd0)};
            else if (sel <= 3)
            begin
                // small values that chop to a few units
                ex = 8'($urandom_range(129, 126));
                v  = {r[31], ex, r[22:21], 21'd0};
            end
            else if (sel <= 6)
            begin
                // across the fraction, integer and clamp ranges
                ex = 8'($urandom_range(160, 118));
                v  = {r[31], ex, r[22:0]};
            end
            else
                v = r;
        end
        else
        begin
            case (sel)
                0, 1, 2, 3: v = r;
                4, 5, 6:    v = $urandom_range(8) - 32'd4;
                7:          v = cmp;
                8:          v = r[0] ? cmp + 32'd1 : cmp - 32'd1;
                default:    v = r[0] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            endcase
        end
        return swap_bytes(v);
    endfunction

    // sender: offers queued column words, gaps only between requests
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
                predict_projection(raw_word);
            if (!in_valid || in_ready)
            begin
                if (pending_words.size() != 0 && (no_idle || $urandom_range(99) >= 22))
                begin
                    in_valid <= 1'b1;
                    raw_word <= pending_words.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // long output hold, counted here once armed
    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_arm && !hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // receiver: checks each taken column against the oldest one owed
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_cols.size() == 0)
                begin
                    if (mismatches < REPORT_LIMIT)
                        $display("column %0d value %h last %b out with none owed",
                                 column_index, column_value, last_of_row);
                    mismatches++;
                end
                else
                begin
                    want_col = expected_cols.pop_front();
                    if (want_col.idx !== column_index || want_col.value !== column_value ||
                        want_col.is_last !== last_of_row)
                    begin
                        if (mismatches < REPORT_LIMIT)
                            $display("column mismatch: want %0d %h %b, got %0d %h %b",
                                     want_col.idx, want_col.value, want_col.is_last,
                                     column_index, column_value, last_of_row);
                        mismatches++;
                    end
                end
            end
            out_ready <= (hold_left == 0) && (no_idle || $urandom_range(99) >= 22);
        end
    end

    initial
    begin
        #2_000_000;
        $display("[row_filter_and_project_core] ERROR");
        $finish;
    end

    initial
    begin : stimulus
        int          phase;
        int          rows;
        int          eff;
        int          random_words;
        int          i;
        logic [4:0]  cc;
        logic [15:0] fmask;
        logic [3:0]  filt;
        logic [2:0]  op;
        logic [31:0] cval;
        logic [15:0] pmask;

        regs              = '0;
        regs.column_count = 5'd1;
        col_pos           = 0;
        random_words      = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // count of zero acts as one, every row passes against the minimum
        // word extremes, mask bits past the row end ignored
        apply_config(5'd0, 16'h0000, 4'd0, rfp_pkg::OP_GE, 32'h8000_0000, 16'hFFFF);
        pending_words.insert(pending_words.size(), 32'h0000_0000);
        pending_words.insert(pending_words.size(), 32'hFFFF_FFFF);
        pending_words.insert(pending_words.size(), 32'h7856_3412);
        wait_idle();

        // count above the store acts as sixteen, all float corners, last column tested
        apply_config(5'd31, 16'hFFFF, 4'd15, rfp_pkg::OP_NE, 32'd0, 16'hFFFF);
        for (i = 0; i < ROW_MAX; i++)
            pending_words.insert(pending_words.size(), swap_bytes(FLOAT_CASES[32*i +: 32]));
        wait_idle();

        // count shrunk in the middle of a row ends it on the next word
        apply_config(5'd4, 16'h0000, 4'd1, rfp_pkg::OP_EQ, 32'd5, 16'h000A);
        pending_words.insert(pending_words.size(), swap_bytes(32'h0000_0011));
        pending_words.insert(pending_words.size(), swap_bytes(32'd5));
        wait_idle();
        write_reg(rfp_pkg::REG_COLUMN_COUNT, 32'd2);
        // spare slots, must not disturb anything
        write_reg(REG_SPARE_6, $urandom);
        write_reg(REG_SPARE_7, $urandom);
        cfg_valid <= 1'b0;
        pending_words.insert(pending_words.size(), swap_bytes(32'h0000_0022));
        wait_idle();

        // filter column beyond the row end, nothing gets through
        write_reg(rfp_pkg::REG_FILTER_COLUMN, 32'd3);
        write_reg(rfp_pkg::REG_COMPARE_OP, {29'd0, rfp_pkg::OP_NE});
        cfg_valid <= 1'b0;
        pending_words.insert(pending_words.size(), $urandom);
        pending_words.insert(pending_words.size(), $urandom);
        wait_idle();

        // random phases of whole rows, one setting per phase
        phase = 0;
        while (random_words < RANDOM_WORDS)
        begin
            if (phase == 0)
            begin
                // every row passes with all columns out while the output holds off
                cc   = 5'd4;
                cval = 32'h7FFF_FFFF;
                apply_config(cc, 16'h0000, 4'd0, rfp_pkg::OP_LE, cval, 16'hFFFF);
                fmask    = 16'h0000;
                rows     = 10;
                hold_arm <= 1'b1;
            end
            else
            begin
                case ($urandom_range(9))
                    0:       cc = 5'd0;
                    1:       cc = 5'd16;
                    2:       cc = 5'($urandom_range(31, 6));
                    default: cc = 5'($urandom_range(5, 1));
                endcase
                eff = eff_count(cc);
                case ($urandom_range(3))
                    0:       fmask = 16'h0000;
                    1:       fmask = 16'hFFFF;
                    default: fmask = 16'($urandom);
                endcase
                filt = ($urandom_range(6) == 0) ? 4'($urandom_range(15))
                                                : 4'($urandom_range(eff - 1));
                if ($urandom_range(9) == 0)
                    op = ($urandom_range(1) != 0) ? OP_SPARE_6 : OP_SPARE_7;
                else
                    op = 3'($urandom_range(5));
                case ($urandom_range(3))
                    0:       cval = $urandom;
                    1:       cval = ($urandom_range(1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
                    default: cval = $urandom_range(8) - 32'd4;
                endcase
                case ($urandom_range(9))
                    0:       pmask = 16'h0000;
                    1:       pmask = 16'hFFFF;
                    default: pmask = 16'($urandom);
                endcase
                apply_config(cc, fmask, filt, op, cval, pmask);
                rows = (eff <= 5) ? int'($urandom_range(6, 2)) : int'($urandom_range(2, 1));
            end
            // one calm phase with no gaps on either side
            no_idle <= (phase == 3);
            eff = eff_count(cc);
            repeat (rows)
                for (i = 0; i < eff; i++)
                    pending_words.insert(pending_words.size(), make_column(fmask[i], cval));
            random_words += rows * eff;
            wait_idle();
            phase++;
        end

        no_idle <= 1'b0;
        wait_idle();
        if (mismatches == 0 && expected_cols.size() == 0)
            $display("[row_filter_and_project_core] OK");
        else
            $display("[row_filter_and_project_core] ERROR");
        $finish;
    end

endmodule
